[rtl/core/dqrk_pkg.sv]
// shared types and constants for the tag deque with remove-by-key
package dqrk_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  // stream field layout
  localparam int OP_W     = 2;
  localparam int FTAG_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam int IN_OP_LSB   = 0;
  localparam int IN_TAG_LSB  = IN_OP_LSB + OP_W;
  localparam int IN_BITS     = IN_TAG_LSB + FTAG_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_ST_LSB  = 0;
  localparam int OUT_TAG_LSB = OUT_ST_LSB + STATUS_W;
  localparam int OUT_OCC_LSB = OUT_TAG_LSB + FTAG_W;
  localparam int OUT_BITS    = OUT_OCC_LSB + OCC_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_PUSH = 2'd1,
    OP_DEQ  = 2'd2,
    OP_REM  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic go;
    op_t  op;
  } cell_cmd_t;

endpackage

[rtl/core/dqrk_cell.sv]
// one slot of the tag chain: holds a tag and its valid bit, shifts toward either neighbor
module dqrk_cell #(
  parameter int TAG_BITS = dqrk_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dqrk_pkg::cell_cmd_t cmd,
  input  logic [TAG_BITS-1:0] key,
  input  logic                left_valid,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic                right_valid,
  input  logic [TAG_BITS-1:0] right_tag,
  input  logic                found_in,
  output logic                valid,
  output logic [TAG_BITS-1:0] tag,
  output logic                found_out
);
  import dqrk_pkg::*;

  logic                valid_r, valid_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                load;
  logic                match;

  assign match     = valid_r && (tag_r == key);
  assign found_out = found_in || match;

  always_comb begin
    load      = 1'b0;
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    unique case (cmd.op)
      OP_ENQ: begin
        // first empty slot after the tail takes the new tag
        if (cmd.go && !valid_r && left_valid) begin
          load      = 1'b1;
          valid_nxt = 1'b1;
          tag_nxt   = key;
        end
      end
      OP_PUSH: begin
        if (cmd.go) begin
          load      = 1'b1;
          valid_nxt = left_valid;
          tag_nxt   = left_tag;
        end
      end
      OP_DEQ: begin
        if (cmd.go) begin
          load      = 1'b1;
          valid_nxt = right_valid;
          tag_nxt   = right_tag;
        end
      end
      OP_REM: begin
        // at and behind the first match the chain closes the gap
        if (cmd.go && found_out) begin
          load      = 1'b1;
          valid_nxt = right_valid;
          tag_nxt   = right_tag;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag_r <= tag_nxt;
    end
  end

  assign valid = valid_r;
  assign tag   = tag_r;

endmodule

[rtl/core/deque_with_remove_by_key.sv]
// top level of the tag deque: cell chain, occupancy count and result register
// one request per cycle while out_tready is high; result is valid the cycle after
// every operation, remove included, finishes in the cycle that the cell chain
// updates, the first-match search rippling through the cells in that cycle
// reset: rst_n synchronous active low clears the cell valid bits, count and result valid
// stored tags have no reset; an empty slot is never read
module deque_with_remove_by_key #(
  parameter int QUEUE_DEPTH = dqrk_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = dqrk_pkg::TAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dqrk_pkg::IN_TDATA_W-1:0]  in_tdata,   // operation, entry_tag
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dqrk_pkg::OUT_TDATA_W-1:0] out_tdata   // status, head_tag, occupancy
);
  import dqrk_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // request decode
  logic                in_fire;
  op_t                 req_op;
  logic [TAG_BITS-1:0] req_key;

  // chain links; the found chain has one position more than there are cells
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [TAG_BITS-1:0]    cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   found_chain;

  logic      q_full, q_empty, tag_found;
  cell_cmd_t cmd;

  logic [CNT_W-1:0]    count_r, count_nxt;
  status_t             status;
  logic [TAG_BITS-1:0] taken;
  logic                ok;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // a new request is taken whenever the result register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign req_op    = op_t'(in_tdata[IN_OP_LSB +: OP_W]);
  assign req_key   = TAG_BITS'(in_tdata[IN_TAG_LSB +: FTAG_W]);

  // valid bits form a thermometer from the head
  assign q_full    = cell_valid[QUEUE_DEPTH-1];
  assign q_empty   = !cell_valid[0];
  assign tag_found = found_chain[QUEUE_DEPTH];

  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                lv, rv;
    logic [TAG_BITS-1:0] lt, rt;

    if (i == 0) begin : g_head
      // head cell sees the incoming tag as its left neighbor for push-front
      assign lv = 1'b1;
      assign lt = req_key;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign lt = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rt = '0;
    end else begin : g_body
      assign rv = cell_valid[i+1];
      assign rt = cell_tag[i+1];
    end

    dqrk_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .key         (req_key),
      .left_valid  (lv),
      .left_tag    (lt),
      .right_valid (rv),
      .right_tag   (rt),
      .found_in    (found_chain[i]),
      .valid       (cell_valid[i]),
      .tag         (cell_tag[i]),
      .found_out   (found_chain[i+1])
    );
  end

  // status, taken tag and new count for the request at the port
  always_comb begin
    status    = ST_OK;
    taken     = '0;
    ok        = 1'b0;
    count_nxt = count_r;
    unique case (req_op)
      OP_ENQ, OP_PUSH: begin
        if (q_full) begin
          status = ST_FULL;
        end else begin
          ok        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else begin
          ok        = 1'b1;
          taken     = cell_tag[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_REM: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else if (!tag_found) begin
          status = ST_NOTFOUND;
        end else begin
          ok        = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
    endcase
  end

  // go bit above the operation code
  assign cmd = {in_fire && ok, req_op};

  // result register, packed low field first
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt                             = 1'b1;
      out_data_nxt                              = '0;
      out_data_nxt[OUT_ST_LSB +: STATUS_W]      = status;
      out_data_nxt[OUT_TAG_LSB +: FTAG_W]       = FTAG_W'(taken);
      out_data_nxt[OUT_OCC_LSB +: OCC_W]        = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // count tracks the number of valid cells
  a_count_matches_cells: assert property (
    @(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r)
  ) else $error("occupancy count differs from valid cells");

  // valid cells stay packed against the head
  a_cells_packed: assert property (
    @(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + 1'b1)) == '0
  ) else $error("gap in the cell chain");

  // a dequeue of a non-empty queue drops the count by one
  a_deq_count: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_fire && req_op == OP_DEQ && !q_empty) |=> (count_r == $past(count_r) - CNT_W'(1))
  ) else $error("dequeue did not decrement the count");

endmodule
